>>> design/msa_pkg.sv
// Shared types for the max-distance seat allocator.
`timescale 1ns / 1ps
`default_nettype none

package msa_pkg;

  // Request operation codes.
  typedef enum logic {
    OP_ENTER = 1'b0,
    OP_LEAVE = 1'b1
  } msa_op_t;

  // Control handed from the sequencer to the gap scoring unit.
  typedef struct packed {
    logic clear;  // start of a new enter scan
    logic valid;  // a map bit is presented this cycle
    logic occ;    // value of that map bit
  } msa_scan_ctl_t;

endpackage

`default_nettype wire

>>> design/max_distance_seat_allocator.sv
// Top level: request sequencer, configuration register and result port.
// An enter request reads the occupancy map one slot per cycle with busy high; the
// result is registered in the final state and strobes as busy falls.
// A leave request keeps busy low and its result strobes in the next cycle; the
// receiver cannot stall. After reset a clearing pass empties the map slot by slot
// with busy high; configuration writes are taken during it. slot_count resets to 512.
`timescale 1ns / 1ps
`default_nettype none

module max_distance_seat_allocator
  import msa_pkg::*;
#(
  parameter int MAX_SLOTS = 512
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       in_operation,
  input  wire logic [8:0] in_leave_slot,
  output logic            out_valid,
  output logic [8:0]      out_slot,
  output logic            out_full_res,
  input  wire logic       cfg_we,
  input  wire logic [9:0] cfg_wdata
);

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int WW = (CW > 10) ? CW : 10;
  localparam logic [WW-1:0] MAX_W = WW'(MAX_SLOTS);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINAL
  } state_t;

  state_t        state_r;
  logic [9:0]    slot_count_r;
  logic [CW-1:0] cnt_r;
  logic [IW-1:0] clr_idx_r;
  logic [IW-1:0] rd_idx_r;
  logic          iss_r;
  logic          pv_r;
  logic [IW-1:0] pidx_r;
  logic          out_valid_r;
  logic [8:0]    out_slot_r;
  logic          out_full_r;

  logic [WW-1:0] cfg_w;
  logic [WW-1:0] live_w;
  logic [CW-1:0] live_cnt;
  logic [IW-1:0] cnt_m1;
  logic [WW-1:0] req_w;
  logic          req_in_range;
  logic          acc;
  logic          acc_leave;
  logic          acc_enter;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic          mem_wdata;
  logic          mem_re;
  logic          mem_rdata;

  msa_scan_ctl_t scan_ctl;
  logic          any;
  logic [CW-1:0] used;
  logic [IW-1:0] prev;
  logic [IW-1:0] best_idx;
  logic [IW-1:0] best_dist;

  logic          full;
  logic [IW-1:0] right;
  logic [IW-1:0] pick;
  logic [WW-1:0] pick_w;

  // Live count: a zero count acts as one, a count above the depth as the depth.
  always_comb begin
    cfg_w = WW'(slot_count_r);
    if (cfg_w == '0) begin
      live_w = WW'(1);
    end else if (cfg_w > MAX_W) begin
      live_w = MAX_W;
    end else begin
      live_w = cfg_w;
    end
    live_cnt     = live_w[CW-1:0];
    req_w        = WW'(in_leave_slot);
    req_in_range = req_w < live_w;
    cnt_m1       = IW'(cnt_r - 1'b1);
  end

  assign busy      = (state_r != S_IDLE);
  assign acc       = start && !busy;
  assign acc_leave = acc && (in_operation == OP_LEAVE);
  assign acc_enter = acc && (in_operation == OP_ENTER);

  // Final choice between the best gap and the right end; an empty row picks slot 0.
  always_comb begin
    full  = (used >= cnt_r);
    right = cnt_m1 - prev;
    if (!any) begin
      pick = '0;
    end else if (right > best_dist) begin
      pick = cnt_m1;
    end else begin
      pick = best_idx;
    end
    pick_w = WW'(pick);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = 1'b0;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
      end
      S_IDLE: begin
        // Freeing an empty slot writes the same zero back.
        mem_we    = acc_leave && req_in_range;
        mem_waddr = req_w[IW-1:0];
      end
      S_FINAL: begin
        mem_we    = !full;
        mem_waddr = pick;
        mem_wdata = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign mem_re = (state_r == S_SCAN) && iss_r;

  assign scan_ctl.clear = acc_enter;
  assign scan_ctl.valid = pv_r;
  assign scan_ctl.occ   = mem_rdata;

  msa_occ_mem #(
    .DEPTH(MAX_SLOTS),
    .AW   (IW)
  ) u_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .re     (mem_re),
    .raddr  (rd_idx_r),
    .rdata_r(mem_rdata)
  );

  msa_scan #(
    .IW(IW),
    .CW(CW)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .idx        (pidx_r),
    .any_r      (any),
    .used_r     (used),
    .prev_r     (prev),
    .best_idx_r (best_idx),
    .best_dist_r(best_dist)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= 10'd512;
    end else if (cfg_we) begin
      slot_count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      iss_r       <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      pv_r        <= (state_r == S_SCAN) && iss_r;
      pidx_r      <= rd_idx_r;
      case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == IW'(MAX_SLOTS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc_leave) begin
            out_valid_r <= 1'b1;
            out_slot_r  <= in_leave_slot;
            out_full_r  <= 1'b0;
          end else if (acc_enter) begin
            cnt_r    <= live_cnt;
            rd_idx_r <= '0;
            iss_r    <= 1'b1;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (iss_r) begin
            if (rd_idx_r == cnt_m1) begin
              iss_r <= 1'b0;
            end else begin
              rd_idx_r <= rd_idx_r + 1'b1;
            end
          end
          if (pv_r && pidx_r == cnt_m1) begin
            state_r <= S_FINAL;
          end
        end
        S_FINAL: begin
          out_valid_r <= 1'b1;
          out_slot_r  <= full ? 9'd0 : pick_w[8:0];
          out_full_r  <= full;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_slot     = out_slot_r;
  assign out_full_res = out_full_r;

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(acc_leave) || $past(state_r == S_FINAL)))
    else $error("result strobe without a finished request");

  a_enter_holds_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc_enter |=> busy)
    else $error("enter request did not hold busy");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !mem_we)
    else $error("map written during an enter scan");

  a_full_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_full_res) |-> (out_slot == 9'd0 && !$past(mem_we)))
    else $error("full result changed the map or named a slot");

endmodule

`default_nettype wire

>>> design/msa_occ_mem.sv
// Occupancy map storage: one bit per slot, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module msa_occ_mem #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic          wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic               rdata_r
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/msa_scan.sv
// Gap scoring unit: walks the map bits in slot order and keeps the best gap so far.
`timescale 1ns / 1ps
`default_nettype none

module msa_scan
  import msa_pkg::*;
#(
  parameter int IW = 9,
  parameter int CW = 10
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire msa_scan_ctl_t ctl,
  input  wire logic [IW-1:0] idx,
  output logic               any_r,
  output logic [CW-1:0]      used_r,
  output logic [IW-1:0]      prev_r,
  output logic [IW-1:0]      best_idx_r,
  output logic [IW-1:0]      best_dist_r
);

  logic [IW:0]   sum;
  logic [IW-1:0] mid;
  logic [IW-1:0] gap_dist;

  // Interior gaps are scored at their left-biased midpoint.
  always_comb begin
    sum      = {1'b0, prev_r} + {1'b0, idx};
    mid      = sum[IW:1];
    gap_dist = mid - prev_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      any_r       <= 1'b0;
      used_r      <= '0;
      prev_r      <= '0;
      best_idx_r  <= '0;
      best_dist_r <= '0;
    end else if (ctl.valid && ctl.occ) begin
      used_r <= used_r + 1'b1;
      prev_r <= idx;
      any_r  <= 1'b1;
      if (!any_r) begin
        // The left end is scored by its distance to the first occupied slot.
        best_idx_r  <= '0;
        best_dist_r <= idx;
      end else if (gap_dist > best_dist_r) begin
        best_idx_r  <= mid;
        best_dist_r <= gap_dist;
      end
    end
  end

endmodule

`default_nettype wire

>>> sim/max_distance_seat_allocator_tb.sv
// Self-checking testbench for the max-distance seat allocator.
`timescale 1ns / 1ps

module max_distance_seat_allocator_tb
  import msa_pkg::*;
();

  localparam int SLOT_LIMIT  = 512;
  localparam int CYCLE_LIMIT = 2_500_000;

  typedef struct packed {
    logic [8:0] slot;
    logic       full_res;
  } seat_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       in_operation = 1'b0;
  logic [8:0] in_leave_slot = '0;
  logic       out_valid;
  logic [8:0] out_slot;
  logic       out_full_res;
  logic       cfg_we = 1'b0;
  logic [9:0] cfg_wdata = '0;

  // Local copy of the block's state used for prediction.
  bit           seat_map [SLOT_LIMIT];
  logic [9:0]   slot_count_reg = 10'd512;
  seat_result_t expected_seats [$];
  bit           req_on = 1'b0;

  int error_count   = 0;
  int cycle_count   = 0;
  int enter_total   = 0;
  int leave_total   = 0;
  int full_total    = 0;
  int setting_total = 0;

  max_distance_seat_allocator #(
    .MAX_SLOTS(SLOT_LIMIT)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_leave_slot(in_leave_slot),
    .out_valid    (out_valid),
    .out_slot     (out_slot),
    .out_full_res (out_full_res),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int live_count();
    if (slot_count_reg == 10'd0) return 1;
    if (slot_count_reg > SLOT_LIMIT) return SLOT_LIMIT;
    return int'(slot_count_reg);
  endfunction

  // Predicts the result of one request and updates the local seat map.
  function automatic seat_result_t compute_seat(msa_op_t op, logic [8:0] req);
    int cnt;
    int prev;
    int best_idx;
    int best_dist;
    int used;
    int mid;
    bit any;
    seat_result_t res;
    cnt = live_count();
    res.slot = req;
    res.full_res = 1'b0;
    if (op == OP_LEAVE) begin
      leave_total++;
      if (req < cnt && seat_map[req]) seat_map[req] = 1'b0;
      return res;
    end
    enter_total++;
    any = 1'b0;
    prev = 0;
    best_idx = 0;
    best_dist = 0;
    used = 0;
    for (int i = 0; i < cnt; i++) begin
      if (seat_map[i]) begin
        used++;
        if (!any) begin
          // The left end scores its distance to the first occupied slot.
          any = 1'b1;
          best_idx = 0;
          best_dist = i;
        end else begin
          mid = (prev + i) / 2;
          if (mid - prev > best_dist) begin
            best_dist = mid - prev;
            best_idx = mid;
          end
        end
        prev = i;
      end
    end
    if (used >= cnt) begin
      full_total++;
      res.slot = '0;
      res.full_res = 1'b1;
      return res;
    end
    if (any && (cnt - 1 - prev) > best_dist) best_idx = cnt - 1;
    seat_map[best_idx] = 1'b1;
    res.slot = 9'(best_idx);
    return res;
  endfunction

  // Returns a random occupied slot below the bound, or -1 if there is none.
  function automatic int pick_taken_slot(int bound);
    int taken [$];
    for (int i = 0; i < bound; i++) begin
      if (seat_map[i]) taken = {taken, i};
    end
    if (taken.size() == 0) return -1;
    return taken[$urandom_range(0, taken.size() - 1)];
  endfunction

  always @(posedge clk) begin
    seat_result_t exp_res;
    if (out_valid === 1'b1) begin
      if (expected_seats.size() == 0) begin
        $error("unexpected result: slot %0d full_res %0d", out_slot, out_full_res);
        error_count++;
      end else begin
        exp_res = expected_seats.pop_front();
        if (out_slot !== exp_res.slot) begin
          $error("slot mismatch: expected %0d, actual %0d", exp_res.slot, out_slot);
          error_count++;
        end
        if (out_full_res !== exp_res.full_res) begin
          $error("full_res mismatch: expected %0d, actual %0d", exp_res.full_res,
                 out_full_res);
          error_count++;
        end
      end
    end
  end

  task automatic send_request(input msa_op_t op, input logic [8:0] slot_arg,
                              input int idle_pct);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      if (req_on) begin
        start <= 1'b0;
        req_on = 1'b0;
      end
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    if (!req_on) begin
      start <= 1'b1;
      req_on = 1'b1;
    end
    in_operation  <= op;
    in_leave_slot <= slot_arg;
    do @(posedge clk); while (busy !== 1'b0);
    expected_seats = {expected_seats, compute_seat(op, slot_arg)};
  endtask

  // Holds off new requests until every expected result has come back.
  task automatic drain_results();
    if (req_on) begin
      start <= 1'b0;
      req_on = 1'b0;
    end
    while (expected_seats.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_slot_count(input logic [9:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    slot_count_reg = value;
    setting_total++;
  endtask

  task automatic test_row_ends();
    // Empty row, then right end, then interior midpoints at the full width.
    send_request(OP_ENTER, 9'd0, 0);
    send_request(OP_ENTER, 9'd511, 0);
    send_request(OP_ENTER, 9'd0, 0);
    send_request(OP_ENTER, 9'd0, 0);
    send_request(OP_LEAVE, 9'd511, 0);
    // The same slot a second time is already empty.
    send_request(OP_LEAVE, 9'd511, 0);
    send_request(OP_ENTER, 9'h1ff, 0);
    send_request(OP_LEAVE, 9'd0, 0);
    send_request(OP_ENTER, 9'd0, 0);
  endtask

  task automatic test_count_extremes();
    // A count of zero behaves as a single slot, which is already taken.
    write_slot_count(10'd0);
    send_request(OP_ENTER, 9'd0, 0);
    send_request(OP_LEAVE, 9'd1, 0);
    send_request(OP_LEAVE, 9'd511, 0);
    send_request(OP_LEAVE, 9'd0, 0);
    send_request(OP_ENTER, 9'd0, 0);
    send_request(OP_ENTER, 9'd0, 0);
    // Values above the slot limit are clamped to it.
    write_slot_count(10'h3ff);
    send_request(OP_ENTER, 9'd0, 0);
  endtask

  task automatic test_small_row();
    write_slot_count(10'd3);
    send_request(OP_LEAVE, 9'd0, 0);
    send_request(OP_LEAVE, 9'd1, 0);
    send_request(OP_LEAVE, 9'd2, 0);
    send_request(OP_ENTER, 9'd0, 0);
    send_request(OP_ENTER, 9'd0, 0);
    send_request(OP_ENTER, 9'd0, 0);
    send_request(OP_ENTER, 9'd0, 0);
    send_request(OP_LEAVE, 9'd2, 0);
  endtask

  task automatic run_random_phase(input logic [9:0] count_value, input int n_items,
                                  input int idle_pct);
    int roll;
    int pick;
    logic [8:0] leave_at;
    write_slot_count(count_value);
    for (int k = 0; k < n_items; k++) begin
      roll = $urandom_range(0, 99);
      leave_at = 9'($urandom_range(0, SLOT_LIMIT - 1));
      if (roll < 55) begin
        send_request(OP_ENTER, leave_at, idle_pct);
      end else begin
        // Mostly free slots that are really taken, so the row keeps churning.
        if (roll < 85) begin
          pick = pick_taken_slot(roll < 80 ? live_count() : SLOT_LIMIT);
          if (pick >= 0) leave_at = 9'(pick);
        end
        send_request(OP_LEAVE, leave_at, idle_pct);
      end
      if (idle_pct != 0 && $urandom_range(0, 63) == 0) drain_results();
    end
  endtask

  task automatic test_random_mix();
    run_random_phase(10'd8, 150, 30);
    run_random_phase(10'd1, 40, 30);
    run_random_phase(10'd2, 40, 0);
    run_random_phase(10'd512, 60, 25);
    run_random_phase(10'($urandom_range(3, 64)), 150, 40);
    run_random_phase(10'd0, 30, 20);
    run_random_phase(10'h3ff, 50, 20);
    run_random_phase(10'($urandom_range(65, 200)), 80, 30);
    // Shrinking the row leaves taken slots above the count behind.
    run_random_phase(10'd5, 100, 25);
    run_random_phase(10'd33, 100, 35);
    run_random_phase(10'd17, 100, 0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // Wait out the clearing pass that follows reset.
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    test_row_ends();
    test_count_extremes();
    test_small_row();
    test_random_mix();
    drain_results();
    repeat (SLOT_LIMIT + 8) @(posedge clk);
    if (expected_seats.size() != 0) begin
      $error("%0d expected results never arrived", expected_seats.size());
      error_count++;
    end
    $display("Run covered %0d enter and %0d leave requests, %0d of them on a full row,",
             enter_total, leave_total, full_total);
    $display("across %0d slot-count settings; %0d mismatches seen.", setting_total,
             error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
